// ===== rtl/ikvt_pkg.sv =====
// Package: shared types, constants and codes of the ini key/value tokenizer.
`default_nettype none
package ikvt_pkg;

  localparam int unsigned NameMaxDef  = 16;
  localparam int unsigned SpaceRunDef = 62;

  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChRbr   = 8'h5D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChZ     = 8'h7A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_SECTION, M_KEY, M_SUBKEY, M_VALUE
  } mode_e;

  typedef enum logic [1:0] {
    K_NAME = 2'd0, K_NAME_END = 2'd1, K_VALUE = 2'd2, K_RECORD_END = 2'd3
  } kind_e;

  // emission sequencer states
  typedef enum logic [2:0] {
    S_SCAN, S_SEC, S_SEC_DOT, S_KEY, S_SUB_DOT, S_SUB, S_NAME_END, S_SPACES
  } seq_e;

  // which name store a character goes to
  typedef enum logic [1:0] {
    P_SEC, P_KEY, P_SUB
  } part_e;

  typedef struct packed {
    logic  clear_all;
    logic  store_en;
    part_e store_part;
    logic  clr_sec;
    logic  clr_key;
    logic  clr_sub;
    logic  latch_trunc;
    logic  spc_inc;
    logic  spc_clr;
    logic  spc_dec;
    logic  idx_clr;
    logic  idx_inc;
    part_e rd_part;
  } dp_cmd_t;

  typedef struct packed {
    logic [4:0] sec_len;
    logic [4:0] key_len;
    logic [4:0] sub_len;
    logic [5:0] spaces;
    logic [4:0] idx;
    logic [7:0] rd_char;
    logic       trunc;
  } dp_sts_t;

  function automatic logic is_ws(logic [7:0] b);
    return b == ChSpace || b == ChTab || b == ChCr || b == ChLf;
  endfunction

  function automatic logic is_eol(logic [7:0] b);
    return b == ChCr || b == ChLf;
  endfunction

  function automatic logic is_name_ch(logic [7:0] b);
    return b > ChSpace && b <= ChZ;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ikvt_if.sv =====
// Interfaces: input and result channels with valid/ready handshake.
`default_nettype none
interface ikvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_done;
  modport source (output valid, text_byte, text_done, input ready);
  modport sink (input valid, text_byte, text_done, output ready);
endinterface

interface ikvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] out_kind;
  logic       name_truncated;
  logic       space_overflow;
  logic       run_last;
  modport source (output valid, out_char, out_kind, name_truncated, space_overflow,
                  run_last, input ready);
  modport sink (input valid, out_char, out_kind, name_truncated, space_overflow,
                run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ikvt_datapath.sv =====
// Datapath: name stores, lengths, space counter and read index.
`default_nettype none
module ikvt_datapath #(
  parameter int unsigned NameMax = ikvt_pkg::NameMaxDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       byte_i,
  input  wire ikvt_pkg::dp_cmd_t cmd_i,
  output ikvt_pkg::dp_sts_t     sts_o
);
  import ikvt_pkg::*;

  localparam int unsigned Aw = $clog2(NameMax);
  localparam logic [4:0] Max  = 5'(NameMax);
  localparam logic [4:0] Over = 5'(NameMax + 1);

  logic [7:0] sec_mem [NameMax];
  logic [7:0] key_mem [NameMax];
  logic [7:0] sub_mem [NameMax];
  logic [4:0] sec_len_q, key_len_q, sub_len_q, idx_q;
  logic [5:0] spc_q;
  logic       trunc_q;
  logic [4:0] wr_len;
  logic       any_over;

  always_comb begin
    unique case (cmd_i.store_part)
      P_SEC:   wr_len = sec_len_q;
      P_KEY:   wr_len = cmd_i.clr_key ? 5'd0 : key_len_q;
      default: wr_len = cmd_i.clr_sub ? 5'd0 : sub_len_q;
    endcase
  end

  assign any_over = sec_len_q > Max || key_len_q > Max || sub_len_q > Max;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en && wr_len < Max) begin
      unique case (cmd_i.store_part)
        P_SEC:   sec_mem[wr_len[Aw-1:0]] <= byte_i;
        P_KEY:   key_mem[wr_len[Aw-1:0]] <= byte_i;
        default: sub_mem[wr_len[Aw-1:0]] <= byte_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_len_q <= '0;
      key_len_q <= '0;
      sub_len_q <= '0;
      spc_q     <= '0;
      idx_q     <= '0;
      trunc_q   <= 1'b0;
    end else if (cmd_i.clear_all) begin
      sec_len_q <= '0;
      key_len_q <= '0;
      sub_len_q <= '0;
      spc_q     <= '0;
      idx_q     <= '0;
      trunc_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_sec) sec_len_q <= '0;
      if (cmd_i.clr_key && !cmd_i.store_en) key_len_q <= '0;
      if (cmd_i.clr_sub) sub_len_q <= '0;
      if (cmd_i.store_en) begin
        unique case (cmd_i.store_part)
          P_SEC:   sec_len_q <= wr_len < Max ? wr_len + 5'd1 : Over;
          P_KEY:   key_len_q <= wr_len < Max ? wr_len + 5'd1 : Over;
          default: sub_len_q <= wr_len < Max ? wr_len + 5'd1 : Over;
        endcase
      end
      if (cmd_i.latch_trunc) trunc_q <= any_over;
      if (cmd_i.spc_clr) spc_q <= '0;
      else if (cmd_i.spc_dec) spc_q <= spc_q - 6'd1;
      else if (cmd_i.spc_inc) spc_q <= spc_q + 6'd1;
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 5'd1;
    end
  end

  always_comb begin
    sts_o.sec_len = sec_len_q > Max ? Max : sec_len_q;
    sts_o.key_len = key_len_q > Max ? Max : key_len_q;
    sts_o.sub_len = sub_len_q > Max ? Max : sub_len_q;
    sts_o.spaces  = spc_q;
    sts_o.idx     = idx_q;
    sts_o.trunc   = trunc_q;
    unique case (cmd_i.rd_part)
      P_SEC:   sts_o.rd_char = sec_mem[idx_q[Aw-1:0]];
      P_KEY:   sts_o.rd_char = key_mem[idx_q[Aw-1:0]];
      default: sts_o.rd_char = sub_mem[idx_q[Aw-1:0]];
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ikvt_ctrl.sv =====
// Controller: parse mode, emission sequencer and result register.
`default_nettype none
module ikvt_ctrl #(
  parameter int unsigned SpaceRun = ikvt_pkg::SpaceRunDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ikvt_in_if.sink               in_if,
  ikvt_out_if.source            out_if,
  input  wire ikvt_pkg::dp_sts_t sts_i,
  output ikvt_pkg::dp_cmd_t     cmd_o
);
  import ikvt_pkg::*;

  localparam logic [5:0] Run = 6'(SpaceRun);

  mode_e mode_q, mode_d;
  seq_e  seq_q, seq_d;
  logic  ovf_q, ovf_d;
  logic  after_q, after_d;     // value char pending after space release
  logic [7:0] pend_q, pend_d;

  logic       ov_q, ov_d;
  logic [7:0] oc_q, oc_d;
  logic [1:0] ok_q, ok_d;
  logic       ot_q, ot_d, oo_q, oo_d, ol_q, ol_d;

  logic       free;
  logic       emit;
  logic [7:0] e_char;
  kind_e      e_kind;
  logic       e_trunc, e_ovf, e_last;
  logic [7:0] b;
  logic       take;

  assign free        = !ov_q || out_if.ready;
  assign in_if.ready = seq_q == S_SCAN && free;
  assign take        = in_if.valid && in_if.ready;
  assign b           = in_if.text_byte;

  assign out_if.valid          = ov_q;
  assign out_if.out_char       = oc_q;
  assign out_if.out_kind       = ok_q;
  assign out_if.name_truncated = ot_q;
  assign out_if.space_overflow = oo_q;
  assign out_if.run_last       = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      seq_q   <= S_SCAN;
      ovf_q   <= 1'b0;
      after_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      seq_q   <= seq_d;
      ovf_q   <= ovf_d;
      after_q <= after_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    oc_q   <= oc_d;
    ok_q   <= ok_d;
    ot_q   <= ot_d;
    oo_q   <= oo_d;
    ol_q   <= ol_d;
  end

  // first step after the name starts: pick the first non-empty part
  function automatic seq_e name_start(dp_sts_t s);
    if (s.sec_len != 0) return S_SEC;
    if (s.key_len != 0) return S_KEY;
    if (s.sub_len != 0) return S_SUB_DOT;
    return S_NAME_END;
  endfunction

  always_comb begin
    cmd_o    = '0;
    cmd_o.store_part = P_KEY;
    cmd_o.rd_part    = P_KEY;
    mode_d  = mode_q;
    seq_d   = seq_q;
    ovf_d   = ovf_q;
    after_d = after_q;
    pend_d  = pend_q;
    emit    = 1'b0;
    e_char  = 8'd0;
    e_kind  = K_NAME;
    e_trunc = 1'b0;
    e_ovf   = 1'b0;
    e_last  = 1'b0;

    unique case (seq_q)
      S_SCAN: begin
        if (take) begin
          if (in_if.text_done) begin
            if (mode_q == M_VALUE) begin
              emit = 1'b1; e_kind = K_RECORD_END; e_last = 1'b1;
            end
            cmd_o.clear_all = 1'b1;
            mode_d = M_IDLE;
          end else begin
            logic disp;
            disp = 1'b0;
            unique case (mode_q)
              M_COMMENT: if (is_eol(b)) mode_d = M_IDLE;
              M_SECTION: begin
                if (is_eol(b) || b == ChRbr) mode_d = M_IDLE;
                else begin
                  cmd_o.store_en = 1'b1; cmd_o.store_part = P_SEC;
                end
              end
              M_KEY, M_SUBKEY: begin
                if (is_name_ch(b) && b != ChEq) begin
                  cmd_o.store_en = 1'b1;
                  cmd_o.store_part = mode_q == M_KEY ? P_KEY : P_SUB;
                end else disp = 1'b1;
              end
              M_VALUE: begin
                if (b >= ChSpace && b <= ChDel && b != ChSemi) begin
                  if (b == ChSpace) begin
                    if (sts_i.spaces >= Run) begin
                      seq_d = S_SPACES; ovf_d = 1'b1; after_d = 1'b0;
                    end else cmd_o.spc_inc = 1'b1;
                  end else if (sts_i.spaces != 0) begin
                    seq_d = S_SPACES; ovf_d = 1'b0; after_d = 1'b1; pend_d = b;
                  end else begin
                    emit = 1'b1; e_kind = K_VALUE; e_char = b; e_last = 1'b1;
                  end
                end else begin
                  cmd_o.spc_clr = 1'b1;
                  disp = 1'b1;
                end
              end
              default: disp = 1'b1;
            endcase
            if (disp) begin
              mode_d = M_IDLE;
              if (b == ChSemi) mode_d = M_COMMENT;
              else if (b == ChLbr) begin
                cmd_o.clr_sec = 1'b1; mode_d = M_SECTION;
              end else if (b == ChPlus) begin
                cmd_o.clr_sub = 1'b1; mode_d = M_SUBKEY;
              end else if (b == ChEq) begin
                cmd_o.latch_trunc = 1'b1; cmd_o.spc_clr = 1'b1;
                cmd_o.idx_clr = 1'b1; mode_d = M_VALUE;
                seq_d = name_start(sts_i);
              end else if (is_name_ch(b) && b != ChRbr) begin
                cmd_o.clr_key = 1'b1; cmd_o.clr_sub = 1'b1;
                cmd_o.store_en = 1'b1; cmd_o.store_part = P_KEY;
                mode_d = M_KEY;
              end
              if (mode_q == M_VALUE) begin
                emit = 1'b1; e_kind = K_RECORD_END;
                e_last = b != ChEq;
              end
            end
          end
        end
      end
      S_SEC, S_KEY, S_SUB: begin
        cmd_o.rd_part = seq_q == S_SEC ? P_SEC : (seq_q == S_KEY ? P_KEY : P_SUB);
        if (free) begin
          logic [4:0] len;
          len = seq_q == S_SEC ? sts_i.sec_len :
                (seq_q == S_KEY ? sts_i.key_len : sts_i.sub_len);
          if (sts_i.idx < len) begin
            emit = 1'b1; e_char = sts_i.rd_char; cmd_o.idx_inc = 1'b1;
          end else begin
            cmd_o.idx_clr = 1'b1;
            unique case (seq_q)
              S_SEC:   seq_d = S_SEC_DOT;
              S_KEY:   seq_d = sts_i.sub_len != 0 ? S_SUB_DOT : S_NAME_END;
              default: seq_d = S_NAME_END;
            endcase
          end
        end
      end
      S_SEC_DOT: if (free) begin
        emit = 1'b1; e_char = ChDot; seq_d = S_KEY;
      end
      S_SUB_DOT: if (free) begin
        emit = 1'b1; e_char = ChDot; seq_d = S_SUB;
      end
      S_NAME_END: if (free) begin
        emit = 1'b1; e_kind = K_NAME_END; e_trunc = sts_i.trunc; e_last = 1'b1;
        seq_d = S_SCAN;
      end
      S_SPACES: if (free) begin
        if (sts_i.spaces != 0) begin
          emit = 1'b1; e_kind = K_VALUE; e_char = ChSpace; e_ovf = ovf_q;
          e_last = ovf_q && sts_i.spaces == 6'd1;
          cmd_o.spc_dec = 1'b1;
        end else begin
          seq_d = S_SCAN;
          if (after_q) begin
            emit = 1'b1; e_kind = K_VALUE; e_char = pend_q; e_last = 1'b1;
          end else cmd_o.spc_inc = 1'b1;
        end
      end
      default: seq_d = S_SCAN;
    endcase

    ov_d = ov_q && !out_if.ready;
    oc_d = oc_q; ok_d = ok_q; ot_d = ot_q; oo_d = oo_q; ol_d = ol_q;
    if (emit) begin
      ov_d = 1'b1; oc_d = e_char; ok_d = e_kind;
      ot_d = e_trunc; oo_d = e_ovf; ol_d = e_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ini_key_value_tokenizer_core.sv =====
// Top level: ini key/value tokenizer, controller plus name-store datapath.
//
//  channel | dir | handshake      | payload
//  in_if   | in  | valid / ready  | text_byte, text_done
//  out_if  | out | valid / ready  | out_char, out_kind, name_truncated,
//          |     |                | space_overflow, run_last
//
// One byte per cycle while scanning and the result register is free. On '='
// the name is emitted from the stores character by character (at most
// 3*NameMax+3 beats), and a released space run is emitted space by space;
// input is held off meanwhile.
// Reset clears lengths, mode and space count; name stores are not cleared.
// A stalled result register stalls the whole block.
`default_nettype none
module ini_key_value_tokenizer_core #(
  parameter int unsigned NameMax  = ikvt_pkg::NameMaxDef,
  parameter int unsigned SpaceRun = ikvt_pkg::SpaceRunDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  ikvt_in_if.sink    in_if,
  ikvt_out_if.source out_if
);
  import ikvt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ikvt_ctrl #(.SpaceRun(SpaceRun)) u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if, .sts_i(sts), .cmd_o(cmd)
  );

  ikvt_datapath #(.NameMax(NameMax)) u_dp (
    .clk_i, .rst_ni, .byte_i(in_if.text_byte), .cmd_i(cmd), .sts_o(sts)
  );

endmodule
`default_nettype wire

// ===== rtl/ikvt_checker.sv =====
// Checker: port-level properties of the tokenizer, bound to the top level.
`default_nettype none
module ikvt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic [1:0] out_kind,
  input wire logic       name_truncated,
  input wire logic       space_overflow
);
  import ikvt_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_char))
    else $error("result dropped while stalled");

  a_trunc_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && name_truncated |-> out_kind == K_NAME_END)
    else $error("truncation flag off name end");

  a_ovf_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && space_overflow |-> out_kind == K_VALUE && out_char == ChSpace)
    else $error("overflow flag off released space");

  a_end_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == K_NAME_END || out_kind == K_RECORD_END)
      |-> out_char == 8'd0)
    else $error("end result carries a character");

  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind ini_key_value_tokenizer_core ikvt_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_char(out_if.out_char), .out_kind(out_if.out_kind),
  .name_truncated(out_if.name_truncated), .space_overflow(out_if.space_overflow)
);
`default_nettype wire
